[rtl/cia_pkg.sv]
// Package for the consecutive id assigner: payload types, table entry type
// and shared constants. Depends on nothing.
package cia_pkg;

	localparam int KEY_W        = 64;
	localparam int ID_W         = 13;
	localparam int CAPACITY_DEF = 4096;

	// Fibonacci hashing multiplier.
	localparam logic [KEY_W-1:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             domain;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] assigned_id;
		logic            is_new;
		logic            table_full;
	} rsp_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

endpackage

[rtl/cia_hash.sv]
// Home slot unit: one shared 32x32 multiplier forms the upper half of the low
// 64 product bits and, when CAPACITY is not a power of two, also the reciprocal
// and back products that reduce it modulo CAPACITY. Depends on cia_pkg.
module cia_hash #(
	parameter int CAPACITY = cia_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cia_pkg::KEY_W-1:0]   key,
	output logic                        done,
	output logic [$clog2(CAPACITY)-1:0] slot
);
	import cia_pkg::*;

	localparam int  SLOT_W = $clog2(CAPACITY);
	localparam bit  IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
	// Reciprocal of CAPACITY scaled by 2^32. The quotient estimate it gives is
	// never high and at most one short, so one compare and subtract finishes it.
	localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(CAPACITY));
	localparam logic [31:0] DIVISOR = 32'(CAPACITY);

	typedef enum logic [3:0] {
		H_IDLE = 4'b0001,
		H_MUL  = 4'b0010,
		H_RED  = 4'b0100,
		H_DONE = 4'b1000
	} hstate_t;

	hstate_t           state_q;
	logic [1:0]        step_q;
	logic [KEY_W-1:0]  key_q;
	logic [63:0]       prod_q;
	logic [31:0]       acc_q;
	logic [SLOT_W:0]   rem_q;

	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [SLOT_W:0]   rem_fix;

	// Reduction reuses the multiplier: first hash times reciprocal, then the
	// quotient estimate times CAPACITY.
	always_comb begin
		if (state_q == H_RED) begin
			mul_a = (step_q == 2'd0) ? acc_q : prod_q[63:32];
			mul_b = (step_q == 2'd0) ? RECIP : DIVISOR;
		end else begin
			mul_a = (step_q == 2'd1) ? key_q[63:32] : key_q[31:0];
			mul_b = (step_q == 2'd2) ? HASH_MUL[63:32] : HASH_MUL[31:0];
		end
	end

	assign rem_fix = (rem_q >= (SLOT_W+1)'(CAPACITY)) ?
		rem_q - (SLOT_W+1)'(CAPACITY) : rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end
		prod_q <= mul_a * mul_b;
		if (state_q == H_MUL) begin
			case (step_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= prod_q[63:32];
				default: acc_q <= acc_q + prod_q[31:0];
			endcase
		end else if ((state_q == H_RED) && (step_q == 2'd2)) begin
			rem_q <= (SLOT_W+1)'(acc_q - prod_q[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				H_IDLE: begin
					if (start) begin
						state_q <= H_MUL;
						step_q  <= '0;
					end
				end
				H_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= IS_POW2 ? H_DONE : H_RED;
					end
				end
				H_RED: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd2) begin
						state_q <= H_DONE;
					end
				end
				H_DONE: state_q <= H_IDLE;
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done = state_q == H_DONE;
	assign slot = IS_POW2 ? acc_q[SLOT_W-1:0] : rem_fix[SLOT_W-1:0];

endmodule

[rtl/cia_table.sv]
// Slot memory for both dictionaries, one write and one registered read port,
// with a clearing pass of the valid flags after reset. Depends on cia_pkg.
module cia_table #(
	parameter int DEPTH = 2 * cia_pkg::CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output cia_pkg::entry_t          rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  cia_pkg::entry_t          wr_data,
	output logic                     init_done
);
	import cia_pkg::*;

	localparam int AW = $clog2(DEPTH);

	entry_t        mem [DEPTH];
	entry_t        rd_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign rd_data   = rd_q;
	assign init_done = !clr_busy_q;

endmodule

[rtl/consecutive_id_assigner_top.sv]
// Top level of the consecutive id assigner: probe sequencer, id counters and
// result register. Depends on cia_pkg, cia_hash and cia_table.
//
//   Channel | Signals                        | Direction | Moves
//   --------+--------------------------------+-----------+----------------------------
//   req     | req_valid, req_ready, req_data | in        | one item: key, domain
//   rsp     | rsp_valid, rsp_ready, rsp_data | out       | one item: id, is_new, full
//   cfg     | cfg_we, cfg_wdata              | in        | shared dictionary mode bit
//
// An item first passes through the shared hash multiplier, then through the
// reduction on the same multiplier when CAPACITY is not a power of two, and
// the home slot is handed over; every table slot probed then takes a memory
// read, then a compare, and the next item is taken in the idle state.
// After reset a clearing pass walks all 2*CAPACITY slots, one per cycle, and
// req_ready stays low until it is over; configuration writes are taken anyway.
// One item is worked on at a time. A finished item waits in the result
// register, and the next item may be accepted meanwhile; a probe that reaches
// its decision while that register is still full holds until it drains.
module consecutive_id_assigner_top #(
	parameter int CAPACITY = cia_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cia_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cia_pkg::rsp_t rsp_data,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);
	import cia_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int DEPTH  = 2 * CAPACITY;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_HASH = 4'b0010,
		S_LOOK = 4'b0100,
		S_CMP  = 4'b1000
	} state_t;

	state_t            state_q;
	logic              shared_mode_q;
	logic [KEY_W-1:0]  key_q;
	logic              tgt_q;
	logic [SLOT_W-1:0] pos_q;
	logic [CNT_W-1:0]  probe_q;
	logic [CNT_W-1:0]  cnt_src_q;
	logic [CNT_W-1:0]  cnt_tgt_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              hash_done;
	logic [SLOT_W-1:0] hash_slot;
	logic              init_done;
	logic [ADDR_W-1:0] slot_addr;
	entry_t            rd_entry;
	entry_t            wr_entry;
	logic              wr_en;
	logic [CNT_W-1:0]  cnt_sel;
	logic [CNT_W-1:0]  cnt_new;
	logic              dict_full;
	logic              hit;
	logic              empty;
	logic              last_probe;
	logic              out_free;
	logic              produce;
	logic [SLOT_W:0]   pos_inc;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE) && init_done;

	// The slot address is the position inside the dictionary, offset by
	// CAPACITY for the target dictionary.
	assign slot_addr = ADDR_W'(pos_q) + (tgt_q ? ADDR_W'(CAPACITY) : ADDR_W'(0));

	assign cnt_sel    = tgt_q ? cnt_tgt_q : cnt_src_q;
	assign cnt_new    = cnt_sel + CNT_W'(1);
	assign dict_full  = cnt_sel == CNT_W'(CAPACITY);
	assign empty      = !rd_entry.valid;
	assign hit        = rd_entry.valid && (rd_entry.key == key_q);
	assign last_probe = probe_q == CNT_W'(CAPACITY - 1);
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign pos_inc    = {1'b0, pos_q} + (SLOT_W+1)'(1);

	// A result is produced, once the result register is free, when the probe
	// reaches an empty slot, a matching slot, or has walked the whole dictionary without either.
	assign produce = (state_q == S_CMP) && out_free && (empty || hit || last_probe);
	assign wr_en   = produce && empty && !dict_full;

	assign wr_entry.valid = 1'b1;
	assign wr_entry.key   = key_q;
	assign wr_entry.id    = ID_W'(cnt_new);

	cia_hash #(
		.CAPACITY(CAPACITY)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.key   (req_data.key),
		.done  (hash_done),
		.slot  (hash_slot)
	);

	cia_table #(
		.DEPTH(DEPTH)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (slot_addr),
		.rd_data  (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (slot_addr),
		.wr_data  (wr_entry),
		.init_done(init_done)
	);

	// Item context; the domain is resolved against the mode at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= req_data.key;
			tgt_q <= req_data.domain && !shared_mode_q;
		end
		if (state_q == S_HASH) begin
			pos_q   <= hash_slot;
			probe_q <= '0;
		end else if ((state_q == S_CMP) && !empty && !hit && !last_probe) begin
			pos_q   <= (pos_inc == (SLOT_W+1)'(CAPACITY)) ? '0 : pos_inc[SLOT_W-1:0];
			probe_q <= probe_q + CNT_W'(1);
		end
		if (produce) begin
			if (hit) begin
				rsp_q.assigned_id <= rd_entry.id;
				rsp_q.is_new      <= 1'b0;
				rsp_q.table_full  <= 1'b0;
			end else if (empty && !dict_full) begin
				rsp_q.assigned_id <= ID_W'(cnt_new);
				rsp_q.is_new      <= 1'b1;
				rsp_q.table_full  <= 1'b0;
			end else begin
				rsp_q.assigned_id <= '0;
				rsp_q.is_new      <= 1'b0;
				rsp_q.table_full  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			shared_mode_q <= 1'b0;
			cnt_src_q     <= '0;
			cnt_tgt_q     <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				shared_mode_q <= cfg_wdata;
			end
			if (wr_en) begin
				if (tgt_q) begin
					cnt_tgt_q <= cnt_new;
				end else begin
					cnt_src_q <= cnt_new;
				end
			end
			if (produce) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: state_q <= S_CMP;
				S_CMP: begin
					if (produce) begin
						state_q <= S_IDLE;
					end else if (!empty && !hit && !last_probe) begin
						state_q <= S_LOOK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Neither dictionary ever holds more ids than it has slots.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_src_q <= CNT_W'(CAPACITY)) && (cnt_tgt_q <= CNT_W'(CAPACITY)))
		else $error("id counter above capacity");

	// An insertion into the source dictionary bumps the source counter by one.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !tgt_q |=> cnt_src_q == $past(cnt_src_q) + CNT_W'(1))
		else $error("source counter did not advance on insert");

	// No item is taken before the clearing pass has finished.
	a_ready_init: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> init_done)
		else $error("item accepted during clearing pass");

	// A result is only ever loaded into a free result register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |=> !$past(produce))
		else $error("pending result overwritten");

endmodule
